>>> sv/sdf_pkg.sv
package sdf_pkg;

  localparam int ByteWidth = 8;
  localparam int PtrWidth = 16;
  localparam int FuncWidth = 2;
  localparam int StatusWidth = 3;

  localparam logic [ByteWidth-1:0] SLIP_END = 8'hC0;
  localparam logic [ByteWidth-1:0] SLIP_ESC = 8'hDB;
  localparam logic [ByteWidth-1:0] SLIP_ESC_END = 8'hDC;
  localparam logic [ByteWidth-1:0] SLIP_ESC_ESC = 8'hDD;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_PAYLOAD = 2'd1,
    FUNC_DRAIN = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK = 3'd0,
    ST_COLLISION = 3'd1,
    ST_NO_HEADER = 3'd2,
    ST_PREMATURE = 3'd3,
    ST_NOT_RECV = 3'd4,
    ST_COMMITTED = 3'd5
  } status_t;

endpackage

>>> sv/sdf_in_if.sv
interface sdf_in_if
  import sdf_pkg::*;
();
  logic valid;
  logic ready;
  logic [FuncWidth-1:0] func;
  logic [ByteWidth-1:0] raw_byte;
  logic [PtrWidth-1:0] start_pointer;

  modport source (output valid, output func, output raw_byte, output start_pointer,
                  input ready);
  modport sink (input valid, input func, input raw_byte, input start_pointer,
                output ready);
endinterface

>>> sv/sdf_out_if.sv
interface sdf_out_if
  import sdf_pkg::*;
();
  logic valid;
  logic ready;
  logic data_valid;
  logic [ByteWidth-1:0] data_byte;
  logic [StatusWidth-1:0] status;
  logic [PtrWidth-1:0] cursor_out;

  modport source (output valid, output data_valid, output data_byte, output status,
                  output cursor_out, input ready);
  modport sink (input valid, input data_valid, input data_byte, input status,
                input cursor_out, output ready);
endinterface

>>> sv/slip_receive_deframer.sv
// A beat is held in the input register and moves into the result register,
// updating the frame state, once the result register is empty or being taken.
// Throughput: one beat per cycle while out_chan.ready is high; a stalled result
// keeps the input register full and so holds off the input channel.
// Reset (rst_n low, synchronous): both register stages empty, no frame active,
// read cursor zero and no escape pending.
module slip_receive_deframer
  import sdf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  sdf_in_if.sink in_chan,
  sdf_out_if.source out_chan
);

  logic s1_valid_r;
  logic [FuncWidth-1:0] s1_func_r;
  logic [ByteWidth-1:0] s1_byte_r;
  logic [PtrWidth-1:0] s1_start_r;

  logic receiving_r, receiving_nxt;
  logic escape_pending_r, escape_pending_nxt;
  logic [PtrWidth-1:0] read_cursor_r, read_cursor_nxt;

  logic out_valid_r;
  logic data_valid_r, data_valid_nxt;
  logic [ByteWidth-1:0] data_byte_r, data_byte_nxt;
  status_t status_r, status_nxt;

  logic s1_move;
  logic in_take;

  assign s1_move = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign in_take = in_chan.valid && in_chan.ready;

  always_comb begin
    receiving_nxt = receiving_r;
    escape_pending_nxt = escape_pending_r;
    read_cursor_nxt = read_cursor_r;
    data_valid_nxt = 1'b0;
    data_byte_nxt = '0;
    status_nxt = ST_OK;
    case (func_t'(s1_func_r))
      FUNC_BEGIN: begin
        if (receiving_r) begin
          status_nxt = ST_COLLISION;
        end else begin
          read_cursor_nxt = s1_start_r + PtrWidth'(1);
          escape_pending_nxt = 1'b0;
          if (s1_byte_r == SLIP_END) begin
            receiving_nxt = 1'b1;
          end else begin
            status_nxt = ST_NO_HEADER;
          end
        end
      end
      FUNC_PAYLOAD: begin
        if (!receiving_r) begin
          status_nxt = ST_NOT_RECV;
        end else if (escape_pending_r) begin
          if (s1_byte_r == SLIP_ESC_END) begin
            data_byte_nxt = SLIP_END;
          end else if (s1_byte_r == SLIP_ESC_ESC) begin
            data_byte_nxt = SLIP_ESC;
          end else begin
            data_byte_nxt = s1_byte_r;
          end
          data_valid_nxt = 1'b1;
          escape_pending_nxt = 1'b0;
          read_cursor_nxt = read_cursor_r + PtrWidth'(1);
        end else if (s1_byte_r == SLIP_END) begin
          status_nxt = ST_PREMATURE;
        end else if (s1_byte_r == SLIP_ESC) begin
          escape_pending_nxt = 1'b1;
          read_cursor_nxt = read_cursor_r + PtrWidth'(1);
        end else begin
          data_byte_nxt = s1_byte_r;
          data_valid_nxt = 1'b1;
          read_cursor_nxt = read_cursor_r + PtrWidth'(1);
        end
      end
      FUNC_DRAIN: begin
        if (!receiving_r) begin
          status_nxt = ST_NOT_RECV;
        end else begin
          escape_pending_nxt = 1'b0;
          read_cursor_nxt = read_cursor_r + PtrWidth'(1);
          if (s1_byte_r == SLIP_END) begin
            receiving_nxt = 1'b0;
            status_nxt = ST_COMMITTED;
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      receiving_r <= 1'b0;
      escape_pending_r <= 1'b0;
      read_cursor_r <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        receiving_r <= receiving_nxt;
        escape_pending_r <= escape_pending_nxt;
        read_cursor_r <= read_cursor_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_chan.func;
      s1_byte_r <= in_chan.raw_byte;
      s1_start_r <= in_chan.start_pointer;
    end
    if (s1_move) begin
      data_valid_r <= data_valid_nxt;
      data_byte_r <= data_byte_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data_valid = data_valid_r;
  assign out_chan.data_byte = data_byte_r;
  assign out_chan.status = status_r;
  assign out_chan.cursor_out = read_cursor_r;

  // An escape can only be pending inside an active frame.
  a_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    escape_pending_r |-> receiving_r)
    else $error("escape pending outside a frame");

  // A frame only ends through a commit result.
  a_end_by_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(receiving_r)) |-> (out_valid_r && status_r == ST_COMMITTED))
    else $error("frame ended without commit");

  // Decoded data is only delivered with an ok status.
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && data_valid_r) |-> (status_r == ST_OK))
    else $error("data delivered with error status");

  // A held result keeps the cursor it reported.
  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> $stable(read_cursor_r))
    else $error("cursor moved while result stalled");

endmodule
